// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion helpers
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/ctb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctb_pkg
// constants and types shared by the countdown timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

  // bank size and derived widths
  localparam int SLOTS  = 16;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // payload widths fixed by the interface
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 4;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 17;
  localparam int QUO_W  = 16;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [VAL_W-1:0]  ONE_Q16  = 32'h0001_0000;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h1_0000;
  localparam logic [VAL_W-1:0]  VAL_MAX  = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0]  VAL_MIN  = 32'h8000_0000;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_TRIG  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_TRIG,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_QRY_RD,
    ST_QRY_EVAL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/countdown_timer_bank.sv -----
// ----------------------------------------------------------------------------
// countdown_timer_bank
// bank of signed Q16.16 countdown timers kept in two on-chip memories
// ----------------------------------------------------------------------------
// Usage: one command beat enters on the in_ channel (in_cmd, in_slot,
// in_length, in_delta) and exactly one result beat leaves on the out_
// channel. Commands are handled one at a time: in_stall is high from the
// accepting edge until the result has been moved into the output register.
// Sequence per command, from the accepting edge to out_valid:
//   allocate, trigger: the memory write state, then the result state
//   tick: per allocated slot, one read and one write-back
//     on the single memory port
//   query: read and evaluate, then the 16-step serial divider when the ratio needs it
// A finished result waits in the output register while out_stall is high;
// the next command is accepted meanwhile, and its own result waits for the
// register to free up. Reset (rst_n low at a clock edge) empties the bank
// and drops any pending result; timer memories are not cleared, every slot
// is written by allocate before tick touches it.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_timer_bank (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ctb_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [ctb_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic signed [ctb_pkg::VAL_W-1:0] in_length,
  input  wire logic signed [ctb_pkg::VAL_W-1:0] in_delta,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ctb_pkg::SLOT_W-1:0]       out_new_slot,
  output logic                             out_full_res,
  output logic                             out_busy_res,
  output logic [ctb_pkg::FRAC_W-1:0]       out_fraction
);
  import ctb_pkg::*;

  `include "assert_macros.svh"

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    used_count_r;
  logic [CNT_W-1:0]    idx_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;

  // captured command
  logic [SLOT_W-1:0]   slot_r;
  logic [VAL_W-1:0]    length_r;
  logic [VAL_W-1:0]    delta_r;

  // divider and result holding
  logic [VAL_W-1:0]    per_q_r;
  logic [VAL_W-1:0]    div_rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [SLOT_W-1:0]   res_new_slot_r;
  logic                res_full_r;
  logic                res_busy_r;
  logic [FRAC_W-1:0]   res_frac_r;
  logic [SLOT_W-1:0]   out_new_slot_r;
  logic                out_full_r;
  logic                out_busy_r;
  logic [FRAC_W-1:0]   out_frac_r;

  // timer memories
  logic [VAL_W-1:0]    rem_mem [SLOTS];
  logic [VAL_W-1:0]    per_mem [SLOTS];
  logic [VAL_W-1:0]    rd_rem_r;
  logic [VAL_W-1:0]    rd_per_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rem_we;
  logic                per_we;
  logic [VAL_W-1:0]    rem_wd;
  logic [VAL_W-1:0]    per_wd;

  logic                in_acc;
  logic                out_acc;
  logic                out_load;
  logic                bank_full;
  logic                slot_ok;
  logic                tick_end;
  logic [VAL_W:0]      sub_ext;
  logic [VAL_W-1:0]    sub_sat;
  logic                rem_pos;
  logic                per_pos;
  logic [VAL_W:0]      div_shift;
  logic                div_ge;
  logic [VAL_W:0]      div_diff;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign bank_full = used_count_r >= CNT_W'(SLOTS);
  assign slot_ok   = 16'(slot_r) < 16'(SLOTS);
  assign tick_end  = idx_r >= used_count_r;

  // saturating subtract for tick
  assign sub_ext = {rd_rem_r[VAL_W-1], rd_rem_r} - {delta_r[VAL_W-1], delta_r};
  always_comb begin
    if (sub_ext[VAL_W] != sub_ext[VAL_W-1]) begin
      sub_sat = sub_ext[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sub_sat = sub_ext[VAL_W-1:0];
    end
  end

  // sign tests on the read data
  assign rem_pos = !rd_rem_r[VAL_W-1] && (rd_rem_r != '0);
  assign per_pos = !rd_per_r[VAL_W-1] && (rd_per_r != '0);

  // one restoring divide step
  assign div_shift = {div_rem_r, 1'b0};
  assign div_ge    = div_shift >= {1'b0, per_q_r};
  assign div_diff  = div_shift - {1'b0, per_q_r};

  // memory port control
  always_comb begin
    rd_addr = (state_r == ST_TICK_RD) ? ADDR_W'(idx_r) : ADDR_W'(slot_r);
    wr_addr = ADDR_W'(slot_r);
    rem_we  = 1'b0;
    per_we  = 1'b0;
    rem_wd  = length_r;
    per_wd  = length_r;
    case (state_r)
      ST_ALLOC: begin
        wr_addr = ADDR_W'(used_count_r);
        rem_we  = !bank_full;
        per_we  = !bank_full;
        rem_wd  = '0;
        per_wd  = ONE_Q16;
      end
      ST_TRIG: begin
        rem_we = slot_ok;
        per_we = slot_ok;
      end
      ST_TICK_WR: begin
        wr_addr = ADDR_W'(idx_r);
        rem_we  = rem_pos;
        rem_wd  = sub_sat;
      end
      default: begin
      end
    endcase
  end

  // memory arrays with registered read
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wd;
    end
    if (per_we) begin
      per_mem[wr_addr] <= per_wd;
    end
    rd_rem_r <= rem_mem[rd_addr];
    rd_per_r <= per_mem[rd_addr];
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_ALLOC: state_nxt = ST_ALLOC;
            CMD_TRIG:  state_nxt = ST_TRIG;
            CMD_TICK:  state_nxt = ST_TICK_RD;
            default:   state_nxt = ST_QRY_RD;
          endcase
        end
      end
      ST_ALLOC:    state_nxt = ST_DONE;
      ST_TRIG:     state_nxt = ST_DONE;
      ST_TICK_RD:  state_nxt = tick_end ? ST_DONE : ST_TICK_WR;
      ST_TICK_WR:  state_nxt = ST_TICK_RD;
      ST_QRY_RD:   state_nxt = slot_ok ? ST_QRY_EVAL : ST_DONE;
      ST_QRY_EVAL: begin
        if (!per_pos || !rem_pos || ($signed(rd_rem_r) >= $signed(rd_per_r))) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:      state_nxt = (step_r == STEP_W'(QUO_W - 1)) ? ST_DONE : ST_DIV;
      ST_DONE:     state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_ALLOC) && !bank_full) begin
        used_count_r <= used_count_r + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command capture, sequencing and results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r         <= in_slot;
      length_r       <= in_length;
      delta_r        <= in_delta;
      idx_r          <= '0;
      step_r         <= '0;
      res_new_slot_r <= '0;
      res_full_r     <= 1'b0;
      res_busy_r     <= 1'b0;
      res_frac_r     <= '0;
    end
    case (state_r)
      ST_ALLOC: begin
        res_full_r     <= bank_full;
        res_new_slot_r <= bank_full ? '0 : SLOT_W'(used_count_r);
      end
      ST_TICK_WR: begin
        idx_r <= idx_r + CNT_W'(1);
      end
      ST_QRY_EVAL: begin
        res_busy_r <= rem_pos;
        per_q_r    <= rd_per_r;
        div_rem_r  <= rd_rem_r;
        quo_r      <= '0;
        if (per_pos && rem_pos && ($signed(rd_rem_r) >= $signed(rd_per_r))) begin
          res_frac_r <= FRAC_ONE;
        end
      end
      ST_DIV: begin
        step_r    <= step_r + STEP_W'(1);
        div_rem_r <= div_ge ? div_diff[VAL_W-1:0] : div_shift[VAL_W-1:0];
        quo_r     <= {quo_r[QUO_W-2:0], div_ge};
        if (step_r == STEP_W'(QUO_W - 1)) begin
          res_frac_r <= {1'b0, quo_r[QUO_W-2:0], div_ge};
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_new_slot_r <= res_new_slot_r;
      out_full_r     <= res_full_r;
      out_busy_r     <= res_busy_r;
      out_frac_r     <= res_frac_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_new_slot = out_new_slot_r;
  assign out_full_res = out_full_r;
  assign out_busy_res = out_busy_r;
  assign out_fraction = out_frac_r;

  // checks
  `ASSERT_ALWAYS(a_count_bound, used_count_r <= CNT_W'(SLOTS))
  `ASSERT_NEXT(a_alloc_count, (state_r == ST_ALLOC) && !bank_full,
               used_count_r == $past(used_count_r) + CNT_W'(1))
  `ASSERT_IMPL(a_div_rem_below, state_r == ST_DIV, div_rem_r < per_q_r)
  `ASSERT_IMPL(a_full_clean, out_valid_r && out_full_r,
               (out_new_slot_r == '0) && !out_busy_r && (out_frac_r == '0))
  `ASSERT_IMPL(a_frac_range, out_valid_r, out_frac_r <= FRAC_ONE)

endmodule

`default_nettype wire

// ----- dv/countdown_timer_bank_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// countdown_timer_bank_test
// self-checking bench for the countdown timer bank: a queue of commands
// (directed corner cases, then weighted random traffic) feeds a beat driver,
// an in-bench timer model predicts every result and a monitor compares each
// result beat field by field, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_timer_bank_test;
  import ctb_pkg::*;

  localparam int RANDOM_CMDS = 1650;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 60;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    cmd_t                    cmd;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] len_q16;
    logic signed [VAL_W-1:0] dlt_q16;
  } timer_cmd_t;

  typedef struct {
    logic [SLOT_W-1:0] new_slot;
    logic              full_res;
    logic              busy_res;
    logic [FRAC_W-1:0] fraction;
  } timer_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  cmd_t                    in_cmd;
  logic [SLOT_W-1:0]       in_slot;
  logic signed [VAL_W-1:0] in_length;
  logic signed [VAL_W-1:0] in_delta;
  logic                    out_valid;
  logic                    out_stall;
  logic [SLOT_W-1:0]       out_new_slot;
  logic                    out_full_res;
  logic                    out_busy_res;
  logic [FRAC_W-1:0]       out_fraction;

  countdown_timer_bank uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_slot      (in_slot),
    .in_length    (in_length),
    .in_delta     (in_delta),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_new_slot (out_new_slot),
    .out_full_res (out_full_res),
    .out_busy_res (out_busy_res),
    .out_fraction (out_fraction)
  );

  // pending commands and the results they should produce
  timer_cmd_t    cmd_queue[$];
  timer_result_t expected_results[$];

  // timer model state
  logic signed [VAL_W-1:0] remaining_q16[SLOTS];
  logic signed [VAL_W-1:0] period_q16[SLOTS];
  int                      alloc_count;

  // generator bookkeeping: which slots hold defined values
  logic                    slot_written[SLOTS];
  int                      gen_alloc_count;

  int  error_count;
  int  cycle_count;
  int  send_gap_left;
  int  stall_left;
  int  tx_quiet_left;
  int  rx_quiet_left;
  logic beat_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // remaining minus delta, clipped to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat_decrement(
      logic signed [VAL_W-1:0] cur, logic signed [VAL_W-1:0] dlt);
    logic signed [VAL_W:0] diff;
    diff = {cur[VAL_W-1], cur} - {dlt[VAL_W-1], dlt};
    if (diff[VAL_W] != diff[VAL_W-1]) begin
      return diff[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return diff[VAL_W-1:0];
  endfunction

  // remaining over period in Q1.16, clamped to [0, 1]
  function automatic logic [FRAC_W-1:0] timer_ratio(
      logic signed [VAL_W-1:0] cur, logic signed [VAL_W-1:0] per);
    logic [47:0] num;
    logic [47:0] den;
    logic [47:0] quo;
    if (per <= 0 || cur <= 0) return '0;
    if (cur >= per) return FRAC_ONE;
    num = {cur, 16'h0};
    den = {16'h0, per};
    quo = num / den;
    return quo[FRAC_W-1:0];
  endfunction

  // advance the timer model by one accepted command and queue its result
  task automatic apply_timer_cmd(timer_cmd_t c);
    timer_result_t res;
    res = '{new_slot: '0, full_res: 1'b0, busy_res: 1'b0, fraction: '0};
    case (c.cmd)
      CMD_ALLOC: begin
        if (alloc_count >= SLOTS) begin
          res.full_res = 1'b1;
        end else begin
          remaining_q16[alloc_count] = '0;
          period_q16[alloc_count]    = ONE_Q16;
          res.new_slot = alloc_count[SLOT_W-1:0];
          alloc_count++;
        end
      end
      CMD_TRIG: begin
        if (c.slot < SLOTS) begin
          remaining_q16[c.slot] = c.len_q16;
          period_q16[c.slot]    = c.len_q16;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < alloc_count; i++) begin
          if (remaining_q16[i] > 0)
            remaining_q16[i] = sat_decrement(remaining_q16[i], c.dlt_q16);
        end
      end
      default: begin
        if (c.slot < SLOTS) begin
          res.busy_res = remaining_q16[c.slot] > 0;
          res.fraction = timer_ratio(remaining_q16[c.slot], period_q16[c.slot]);
        end
      end
    endcase
    expected_results.push_back(res);
  endtask

  // queue one command, tracking which slots become defined
  task automatic push_cmd(cmd_t cmd, int slot, logic signed [VAL_W-1:0] len_q16,
                          logic signed [VAL_W-1:0] dlt_q16);
    timer_cmd_t c;
    c.cmd     = cmd;
    c.slot    = slot[SLOT_W-1:0];
    c.len_q16 = len_q16;
    c.dlt_q16 = dlt_q16;
    if (cmd == CMD_ALLOC && gen_alloc_count < SLOTS) begin
      slot_written[gen_alloc_count] = 1'b1;
      gen_alloc_count++;
    end
    if (cmd == CMD_TRIG) slot_written[c.slot] = 1'b1;
    cmd_queue.push_back(c);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return VAL_MAX;
      default: return VAL_MIN;
    endcase
  endfunction

  // idle length: mostly none or short, a few long, with quiet stretches
  function automatic int pick_gap(inout int quiet_left);
    int roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // accept command beats into the model, check result beats
  always @(posedge clk) begin
    timer_result_t exp_res;
    cycle_count <= cycle_count + 1;
    beat_taken = rst_n && in_valid && !in_stall;
    if (beat_taken) begin
      apply_timer_cmd(timer_cmd_t'{cmd: in_cmd, slot: in_slot, len_q16: in_length,
                                   dlt_q16: in_delta});
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result beat: new_slot=%0d full=%0b busy=%0b fraction=%0d",
                   out_new_slot, out_full_res, out_busy_res, out_fraction);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_new_slot !== exp_res.new_slot || out_full_res !== exp_res.full_res ||
            out_busy_res !== exp_res.busy_res || out_fraction !== exp_res.fraction) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display({"result mismatch: expected new_slot=%0d full=%0b busy=%0b ",
                      "fraction=%0d, got new_slot=%0d full=%0b busy=%0b fraction=%0d"},
                     exp_res.new_slot, exp_res.full_res, exp_res.busy_res,
                     exp_res.fraction,
                     out_new_slot, out_full_res, out_busy_res, out_fraction);
        end
      end
    end
  end

  // command driver: next beat from the queue after a random gap
  always @(negedge clk) begin
    timer_cmd_t c;
    if (rst_n && (!in_valid || beat_taken)) begin
      if (send_gap_left > 0) begin
        in_valid <= 1'b0;
        send_gap_left--;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        in_cmd    <= c.cmd;
        in_slot   <= c.slot;
        in_length <= c.len_q16;
        in_delta  <= c.dlt_q16;
        in_valid  <= 1'b1;
        send_gap_left = pick_gap(tx_quiet_left);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(rx_quiet_left);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("countdown_timer_bank verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int roll;
    int slot;
    logic signed [VAL_W-1:0] val;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_ALLOC;
    in_slot     = '0;
    in_length   = '0;
    in_delta    = '0;
    out_stall   = 1'b0;
    error_count = 0;
    cycle_count = 0;
    alloc_count = 0;
    gen_alloc_count = 0;
    send_gap_left = 0;
    stall_left    = 0;
    tx_quiet_left = 0;
    rx_quiet_left = 0;
    beat_taken    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      remaining_q16[i] = '0;
      period_q16[i]    = '0;
      slot_written[i]  = 1'b0;
    end

    // directed corner cases
    push_cmd(CMD_ALLOC, 9, 32'h1234_5678, -32'sd7);         // fresh slot, junk fields
    push_cmd(CMD_QUERY, 0, '0, '0);                         // idle new slot
    push_cmd(CMD_TRIG, 0, ONE_Q16, '0);
    push_cmd(CMD_TICK, 3, '0, 32'sh0000_4000);
    push_cmd(CMD_QUERY, 0, '0, '0);                         // three quarters left
    push_cmd(CMD_TRIG, 15, VAL_MAX, '0);                    // unallocated slot
    push_cmd(CMD_TICK, 15, '0, 32'sd1);                     // must skip slot 15
    push_cmd(CMD_QUERY, 15, '0, '0);
    push_cmd(CMD_TICK, 0, '0, -32'sh0000_8000);             // remaining beyond period
    push_cmd(CMD_QUERY, 0, '0, '0);
    push_cmd(CMD_TRIG, 0, VAL_MAX, '0);
    push_cmd(CMD_TICK, 0, '0, VAL_MIN);                     // saturates high
    push_cmd(CMD_QUERY, 0, '0, '0);
    push_cmd(CMD_TRIG, 0, 32'sd5, '0);
    push_cmd(CMD_TICK, 0, '0, 32'sd10);                     // goes below zero
    push_cmd(CMD_TICK, 0, '0, VAL_MAX);                     // expired timer untouched
    push_cmd(CMD_QUERY, 0, '0, '0);
    push_cmd(CMD_TRIG, 0, VAL_MIN, '0);                     // negative period
    push_cmd(CMD_QUERY, 0, '0, '0);
    push_cmd(CMD_TRIG, 1, '0, '0);                          // unallocated, zero length
    push_cmd(CMD_QUERY, 1, '0, '0);
    push_cmd(CMD_ALLOC, 1, '0, '0);                         // overwrites slot 1
    push_cmd(CMD_TRIG, 1, 32'sd3, '0);
    push_cmd(CMD_TICK, 1, '0, 32'sd1);
    push_cmd(CMD_QUERY, 1, '0, '0);                         // fraction two thirds

    // weighted random traffic: mostly load, run down and poll timers
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        push_cmd(CMD_ALLOC, $urandom_range(0, 15), $urandom, $urandom);
      end else if (roll < 30) begin
        if (gen_alloc_count > 0 && $urandom_range(0, 3) != 0)
          slot = $urandom_range(0, gen_alloc_count - 1);
        else
          slot = $urandom_range(0, 15);
        roll = $urandom_range(0, 9);
        if (roll < 8) val = $urandom_range(1, 32'h0004_0000);
        else if (roll < 9) val = $urandom;
        else val = pick_extreme();
        push_cmd(CMD_TRIG, slot, val, $urandom);
      end else if (roll < 55) begin
        roll = $urandom_range(0, 19);
        if (roll < 14) val = $urandom_range(0, 32'h0000_8000);
        else if (roll < 16) val = -$urandom_range(1, 32'h0000_4000);
        else if (roll < 18) val = $urandom;
        else val = pick_extreme();
        push_cmd(CMD_TICK, $urandom_range(0, 15), $urandom, val);
      end else begin
        // poll only slots that hold defined values
        slot = $urandom_range(0, 15);
        if (!slot_written[slot]) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_written[(slot + i) % SLOTS] && !slot_written[slot])
              slot = (slot + i) % SLOTS;
          end
        end
        if (slot_written[slot])
          push_cmd(CMD_QUERY, slot, $urandom, $urandom);
        else
          push_cmd(CMD_TRIG, slot, $urandom_range(1, 32'h0004_0000), $urandom);
      end
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // drain: every beat sent, every result seen, then a quiet tail
    while (cmd_queue.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("countdown_timer_bank verification clean");
    end else begin
      $display("countdown_timer_bank verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
